@@ src/button_press_classifier_core_macros.svh @@
// assertion macros for the button press classifier core
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define BPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bpc assertion failed");
// next-cycle implication
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bpc assertion failed");
`else
`define BPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ src/bpc_pkg.sv @@
// shared types and constants for the button press classifier
`timescale 1ns / 1ps

package bpc_pkg;

	localparam int CFG_BITS     = 24;
	localparam int CFG_IDX_BITS = 8;

	localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE      = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_MIN     = 8'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LONG_MIN      = 8'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DOUBLE_WINDOW = 8'd3;

	localparam logic [CFG_BITS-1:0] DEBOUNCE_RST      = 24'd5000;
	localparam logic [CFG_BITS-1:0] SHORT_MIN_RST     = 24'd100000;
	localparam logic [CFG_BITS-1:0] LONG_MIN_RST      = 24'd1000000;
	localparam logic [CFG_BITS-1:0] DOUBLE_WINDOW_RST = 24'd500000;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} bpc_event_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] debounce_time;
		logic [CFG_BITS-1:0] short_min_us;
		logic [CFG_BITS-1:0] long_min_us;
		logic [CFG_BITS-1:0] dbl_window;
	} bpc_cfg_t;

endpackage

@@ src/bpc_if.sv @@
// channel interfaces: poll input, result output, configuration write
`timescale 1ns / 1ps

interface bpc_poll_if #(parameter int TIME_BITS = 48);
	logic                 valid;
	logic                 ready;
	logic                 raw_pressed;
	logic [TIME_BITS-1:0] now_us;

	modport source (output valid, output raw_pressed, output now_us, input ready);
	modport sink (input valid, input raw_pressed, input now_us, output ready);
endinterface

interface bpc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] press_event;
	logic       stable_level;

	modport source (output valid, output press_event, output stable_level, input ready);
	modport sink (input valid, input press_event, input stable_level, output ready);
endinterface

interface bpc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bpc_pkg::CFG_IDX_BITS-1:0] index;
	logic [bpc_pkg::CFG_BITS-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/bpc_classify.sv @@
// next-state and event logic for one debounced poll
`timescale 1ns / 1ps

module bpc_classify #(
	parameter int TIME_BITS = 48
) (
	input  bpc_pkg::bpc_cfg_t    cfg,
	input  logic                 raw,
	input  logic [TIME_BITS-1:0] now,
	input  logic                 stable,
	input  logic [TIME_BITS-1:0] last_edge,
	input  logic [TIME_BITS-1:0] press_start,
	input  logic [TIME_BITS-1:0] first_rel,
	input  logic                 tap_pending,
	output logic                 stable_n,
	output logic [TIME_BITS-1:0] last_edge_n,
	output logic [TIME_BITS-1:0] press_start_n,
	output logic [TIME_BITS-1:0] first_rel_n,
	output logic                 tap_pending_n,
	output bpc_pkg::bpc_event_t  press_event
);

	logic [TIME_BITS-1:0] since_edge;
	logic [TIME_BITS-1:0] hold_len;
	logic [TIME_BITS-1:0] since_first;
	logic                 edge_ok;
	logic                 first_upd;
	bpc_pkg::bpc_event_t  ev;

	// modular differences
	assign since_edge  = now - last_edge;
	assign hold_len    = now - press_start;
	assign since_first = now - first_rel;
	assign edge_ok     = (raw != stable) && (since_edge >= TIME_BITS'(cfg.debounce_time));

	always_comb begin
		stable_n      = stable;
		last_edge_n   = last_edge;
		press_start_n = press_start;
		first_rel_n   = first_rel;
		tap_pending_n = tap_pending;
		first_upd     = 1'b0;
		ev            = bpc_pkg::EV_NONE;
		if (edge_ok) begin
			stable_n    = raw;
			last_edge_n = now;
			if (raw) begin
				press_start_n = now;
			end else if (hold_len >= TIME_BITS'(cfg.long_min_us)) begin
				ev            = bpc_pkg::EV_LONG;
				tap_pending_n = 1'b0;
			end else if (hold_len >= TIME_BITS'(cfg.short_min_us)) begin
				if (!tap_pending) begin
					tap_pending_n = 1'b1;
					first_rel_n   = now;
					first_upd     = 1'b1;
				end else if (since_first <= TIME_BITS'(cfg.dbl_window)) begin
					ev            = bpc_pkg::EV_DOUBLE;
					tap_pending_n = 1'b0;
				end else begin
					// expired tap reported, this release opens a fresh window
					ev          = bpc_pkg::EV_SINGLE;
					first_rel_n = now;
					first_upd   = 1'b1;
				end
			end
		end
		// a window restarted on this poll has zero elapsed time
		if (ev == bpc_pkg::EV_NONE && tap_pending_n && !first_upd &&
		    since_first > TIME_BITS'(cfg.dbl_window)) begin
			ev            = bpc_pkg::EV_SINGLE;
			tap_pending_n = 1'b0;
		end
	end

	assign press_event = ev;

endmodule

@@ src/button_press_classifier_core.sv @@
// button press classifier top level: debounce and tap/double/long classification
`timescale 1ns / 1ps
`include "button_press_classifier_core_macros.svh"

// a poll is classified as it moves from the input stage into the result register
// throughput: one poll per cycle unless stalled; a full result register lets input fill
// the single input stage and result register form the pipeline; all work is in one pass
// reset: arst_n clears classifier state, both stages empty, config takes its defaults
// configuration writes are taken every cycle on the write channel
module button_press_classifier_core #(
	parameter int TIME_BITS = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	bpc_poll_if.sink     poll,
	bpc_result_if.source result,
	bpc_cfg_if.sink      cfg
);

	bpc_pkg::bpc_cfg_t    cfg_q;

	logic                 vld_s1;
	logic                 raw_s1;
	logic [TIME_BITS-1:0] now_s1;

	logic                 stable_q;
	logic [TIME_BITS-1:0] last_edge_q;
	logic [TIME_BITS-1:0] press_start_q;
	logic [TIME_BITS-1:0] first_rel_q;
	logic                 tap_pending_q;

	logic                 stable_n;
	logic [TIME_BITS-1:0] last_edge_n;
	logic [TIME_BITS-1:0] press_start_n;
	logic [TIME_BITS-1:0] first_rel_n;
	logic                 tap_pending_n;
	bpc_pkg::bpc_event_t  ev;

	logic                 out_vld_q;
	bpc_pkg::bpc_event_t  ev_q;
	logic                 lvl_q;

	logic                 adv;

	assign adv        = vld_s1 && (!out_vld_q || result.ready);
	assign poll.ready = !vld_s1 || adv;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= bpc_pkg::DEBOUNCE_RST;
			cfg_q.short_min_us  <= bpc_pkg::SHORT_MIN_RST;
			cfg_q.long_min_us   <= bpc_pkg::LONG_MIN_RST;
			cfg_q.dbl_window    <= bpc_pkg::DOUBLE_WINDOW_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bpc_pkg::REG_DEBOUNCE:      cfg_q.debounce_time <= cfg.data;
				bpc_pkg::REG_SHORT_MIN:     cfg_q.short_min_us  <= cfg.data;
				bpc_pkg::REG_LONG_MIN:      cfg_q.long_min_us   <= cfg.data;
				bpc_pkg::REG_DOUBLE_WINDOW: cfg_q.dbl_window    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (poll.ready) begin
			vld_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			raw_s1 <= poll.raw_pressed;
			now_s1 <= poll.now_us;
		end
	end

	bpc_classify #(
		.TIME_BITS(TIME_BITS)
	) u_classify (
		.cfg          (cfg_q),
		.raw          (raw_s1),
		.now          (now_s1),
		.stable       (stable_q),
		.last_edge    (last_edge_q),
		.press_start  (press_start_q),
		.first_rel    (first_rel_q),
		.tap_pending  (tap_pending_q),
		.stable_n     (stable_n),
		.last_edge_n  (last_edge_n),
		.press_start_n(press_start_n),
		.first_rel_n  (first_rel_n),
		.tap_pending_n(tap_pending_n),
		.press_event  (ev)
	);

	// classifier state, updated when a poll moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= 1'b0;
			last_edge_q   <= '0;
			press_start_q <= '0;
			first_rel_q   <= '0;
			tap_pending_q <= 1'b0;
		end else if (adv) begin
			stable_q      <= stable_n;
			last_edge_q   <= last_edge_n;
			press_start_q <= press_start_n;
			first_rel_q   <= first_rel_n;
			tap_pending_q <= tap_pending_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_q  <= ev;
			lvl_q <= stable_n;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.press_event  = ev_q;
	assign result.stable_level = lvl_q;

	`BPC_ASSERT_NOW(a_no_adv_on_stall, clk, arst_n, out_vld_q && !result.ready, !adv)
	`BPC_ASSERT_NEXT(a_level_tracks_state, clk, arst_n, adv, result.stable_level == stable_q)
	`BPC_ASSERT_NOW(a_double_needs_tap, clk, arst_n, adv && ev == bpc_pkg::EV_DOUBLE, tap_pending_q)
	`BPC_ASSERT_NEXT(a_long_clears_tap, clk, arst_n, adv && ev == bpc_pkg::EV_LONG, !tap_pending_q)
	`BPC_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !out_vld_q, poll.ready)

endmodule
